@@ hdl/wb5i_pkg.sv @@
// Shared constants, types and payload structs of the weighted 5x5 blur with inversion.
package wb5i_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned WIDTH_CAP  = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
  localparam int unsigned HEIGHT_CAP = 2048;
  localparam int unsigned STORE_ROWS = 4;
  localparam int unsigned TAP_ROWS   = 5;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned PIX_W      = CH_W * NUM_CH;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam int unsigned JOBQ_DEPTH = 4;
  // Result queue depth must be a power of two.
  localparam int unsigned RESQ_DEPTH = 16;
  localparam int unsigned RES_MAX    = 3;

  localparam int unsigned SUM_W       = 14;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam logic [SUM_W-1:0]   INV_BASE = 14'd8925;
  localparam logic [RECIP_W-1:0] RECIP    = 13'd7490;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [0:0]      opcode;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] red_out;
    logic            last_of_run;
    logic            end_of_frame;
  } res_t;

  // One unit of work for the back end: a pixel column or a drain centre.
  typedef struct packed {
    logic                  is_drain;
    logic                  reload;
    logic [COL_W-1:0]      col;
    logic [DIM_W-1:0]      width;
    logic [1:0]            base;
    logic [STORE_ROWS-1:0] rmask;
    logic                  clear;
    logic [RES_MAX-1:0]    emit;
    logic                  eof;
    logic [PIX_W-1:0]      px;
  } job_t;

endpackage

@@ hdl/wb5i_front.sv @@
// Front end: tracks raster position and drain progress and turns each request into a job.
module wb5i_front import wb5i_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  in_t              item_i,
  input  logic             cfg_wr_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  output logic             job_valid_o,
  output job_t             job_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             done_q, done_d;
  logic             chain_q, chain_d;
  logic [COL_W-1:0] prev_x_q, prev_x_d;
  logic [DIM_W-1:0] prev_y_q, prev_y_d;

  logic [DIM_W-1:0] w, h, first, y;
  logic [COL_W-1:0] c, x;
  logic [ROW_W-1:0] r;
  logic [DIM_W:0]   c_inc, r_inc, t;
  logic             row_end, frame_end, rows2, second, eof;
  logic [POS_W-1:0] w_pos, total, x_full, pos_inc;
  logic [STORE_ROWS-1:0] dmask;

  always_comb begin
    w = width_i;
    if (w == '0) begin
      w = DIM_W'(1);
    end else if (w > DIM_W'(WIDTH_CAP)) begin
      w = DIM_W'(WIDTH_CAP);
    end
    h = height_i;
    if (h == '0) begin
      h = DIM_W'(1);
    end else if (h > DIM_W'(HEIGHT_CAP)) begin
      h = DIM_W'(HEIGHT_CAP);
    end
  end

  // A finished frame restarts at the origin on the next pixel.
  assign c         = done_q ? '0 : col_q;
  assign r         = done_q ? '0 : row_q;
  assign c_inc     = (DIM_W+1)'(c) + 1'b1;
  assign r_inc     = (DIM_W+1)'(r) + 1'b1;
  assign row_end   = c_inc >= {1'b0, w};
  assign frame_end = row_end && (r_inc >= {1'b0, h});

  assign rows2   = h >= DIM_W'(2);
  assign first   = rows2 ? h - DIM_W'(2) : '0;
  assign w_pos   = POS_W'(w);
  assign total   = rows2 ? (w_pos << 1) : w_pos;
  assign second  = pos_q >= w_pos;
  assign x_full  = second ? pos_q - w_pos : pos_q;
  assign x       = x_full[COL_W-1:0];
  assign y       = first + DIM_W'(second);
  assign pos_inc = pos_q + 1'b1;
  assign eof     = pos_inc == total;

  always_comb begin
    for (int i = 0; i < STORE_ROWS; i++) begin
      t = (DIM_W+1)'(y) + (DIM_W+1)'(i);
      dmask[i] = (t >= (DIM_W+1)'(2)) && (t < ({1'b0, h} + (DIM_W+1)'(2)));
    end
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    pos_d       = pos_q;
    done_d      = done_q;
    chain_d     = chain_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (cfg_wr_i) begin
      chain_d = 1'b0;
    end
    if (accept_i) begin
      if (item_i.opcode == OP_PIXEL) begin
        job_valid_o    = 1'b1;
        job_o.col      = c;
        job_o.width    = w;
        job_o.base     = r[1:0];
        job_o.rmask[0] = r >= ROW_W'(4);
        job_o.rmask[1] = r >= ROW_W'(3);
        job_o.rmask[2] = r >= ROW_W'(2);
        job_o.rmask[3] = r >= ROW_W'(1);
        job_o.clear    = c == '0;
        job_o.px       = {item_i.red_in, item_i.green_in, item_i.blue_in};
        if (r >= ROW_W'(2)) begin
          if (row_end) begin
            if (c >= COL_W'(2)) begin
              job_o.emit = 3'b111;
            end else if (c == COL_W'(1)) begin
              job_o.emit = 3'b110;
            end else begin
              job_o.emit = 3'b100;
            end
          end else if (c >= COL_W'(2)) begin
            job_o.emit = 3'b001;
          end
        end
        chain_d = 1'b0;
        pos_d   = '0;
        done_d  = frame_end;
        if (row_end) begin
          col_d = '0;
          row_d = frame_end ? '0 : r + 1'b1;
        end else begin
          col_d = c + 1'b1;
          row_d = r;
        end
      end else if (done_q) begin
        if (pos_q >= total) begin
          done_d = 1'b0;
        end else begin
          job_valid_o    = 1'b1;
          job_o.is_drain = 1'b1;
          job_o.reload   = !(chain_q && (x != '0) && (y == prev_y_q)
                             && (x == prev_x_q + 1'b1));
          job_o.col      = x;
          job_o.width    = w;
          job_o.base     = y[1:0] + 2'd2;
          job_o.rmask    = dmask;
          job_o.emit     = 3'b001;
          job_o.eof      = eof;
          chain_d        = 1'b1;
          prev_x_d       = x;
          prev_y_d       = y;
          pos_d          = eof ? '0 : pos_inc;
          done_d         = !eof;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      pos_q    <= '0;
      done_q   <= 1'b0;
      chain_q  <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      pos_q    <= pos_d;
      done_q   <= done_d;
      chain_q  <= chain_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
    end
  end

endmodule

@@ hdl/wb5i_jobq.sv @@
// Short job queue between the front end and the back end.
module wb5i_jobq import wb5i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam int unsigned PTR_W = $clog2(JOBQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             entry_q [JOBQ_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(JOBQ_DEPTH);
  assign valid_o = count_q != '0;
  assign job_o   = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

@@ hdl/wb5i_back.sv @@
// Back end: line store banks, column sums, 5x5 window, inversion and the result queue.
module wb5i_back import wb5i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  localparam int unsigned PTR_W  = $clog2(RESQ_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RESQ_DEPTH + 1);
  localparam int unsigned CRED_W = CNT_W + 1;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned T_W    = COL_W + 2;

  typedef struct packed {
    logic                  col_ok;
    logic [COL_W-1:0]      col;
    logic                  wr;
    logic [1:0]            base;
    logic [STORE_ROWS-1:0] rmask;
    logic                  clear;
    logic [RES_MAX-1:0]    emit;
    logic                  eof;
    logic [PIX_W-1:0]      px;
  } op_t;

  // Weighted vertical sums of one column: plain, inner-ring and center weights.
  typedef struct packed {
    logic [11:0] c;
    logic [10:0] b;
    logic [10:0] a;
  } colsum_t;

  function automatic logic [1:0] popcnt3(input logic [RES_MAX-1:0] m);
    popcnt3 = 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
  endfunction

  // Sequencer ------------------------------------------------------------
  logic [STEP_W-1:0] step_q, step_d, k_eff;
  logic              last_step, credit_ok, issue;
  logic [T_W-1:0]    t;
  op_t               op;

  logic              s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  op_t               s1_q;
  logic [RES_MAX-1:0] s2_emit_q, s3_emit_q, s4_emit_q;
  logic              s2_eof_q, s3_eof_q, s4_eof_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CRED_W-1:0] inflight;

  assign k_eff     = (job_i.is_drain && job_i.reload) ? step_q : STEP_W'(4);
  assign last_step = !job_i.is_drain || (k_eff == STEP_W'(4));
  assign inflight  = CRED_W'(popcnt3(s1_valid_q ? s1_q.emit : '0))
                   + CRED_W'(popcnt3(s2_valid_q ? s2_emit_q : '0))
                   + CRED_W'(popcnt3(s3_valid_q ? s3_emit_q : '0))
                   + CRED_W'(popcnt3(s4_valid_q ? s4_emit_q : '0));
  assign credit_ok = (CRED_W'(count_q) + inflight) <= CRED_W'(RESQ_DEPTH - RES_MAX);
  assign issue     = job_valid_i && credit_ok;
  assign job_pop_o = issue && last_step;
  assign step_d    = issue ? (last_step ? '0 : step_q + 1'b1) : step_q;

  // A drain centre at x needs window columns x-2 .. x+2.
  assign t = T_W'(job_i.col) + T_W'(k_eff);

  always_comb begin
    op       = '0;
    op.base  = job_i.base;
    op.rmask = job_i.rmask;
    op.eof   = last_step && job_i.eof;
    op.emit  = last_step ? job_i.emit : '0;
    if (job_i.is_drain) begin
      op.col    = COL_W'(t - T_W'(2));
      op.col_ok = (t >= T_W'(2)) && ((t - T_W'(2)) < T_W'(job_i.width));
      op.clear  = k_eff == '0;
    end else begin
      op.col    = job_i.col;
      op.col_ok = 1'b1;
      op.clear  = job_i.clear;
      op.wr     = 1'b1;
      op.px     = job_i.px;
    end
  end

  // Line store: one bank per row slot, all read at the same column --------
  logic [PIX_W-1:0] rd_q [STORE_ROWS];

  for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk_i) begin
      if (issue) begin
        rd_q[b] <= mem[op.col];
        if (op.wr && (op.base == 2'(b))) begin
          mem[op.col] <= op.px;
        end
      end
    end
  end

  // Column sums and window ----------------------------------------------
  logic [PIX_W-1:0] tap [TAP_ROWS];
  colsum_t          newcol [NUM_CH];
  colsum_t          win_q [TAP_ROWS][NUM_CH];
  logic [11:0]      e0, e1, e2, e3, e4;

  always_comb begin
    for (int i = 0; i < STORE_ROWS; i++) begin
      tap[i] = (s1_q.rmask[i] && s1_q.col_ok) ? rd_q[2'(s1_q.base + 2'(i))] : '0;
    end
    tap[TAP_ROWS-1] = s1_q.px;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      e0 = 12'(tap[0][ch*CH_W +: CH_W]);
      e1 = 12'(tap[1][ch*CH_W +: CH_W]);
      e2 = 12'(tap[2][ch*CH_W +: CH_W]);
      e3 = 12'(tap[3][ch*CH_W +: CH_W]);
      e4 = 12'(tap[4][ch*CH_W +: CH_W]);
      newcol[ch].a = 11'(e0 + e1 + e2 + e3 + e4);
      newcol[ch].b = 11'(e0 + ((e1 + e2 + e3) << 1) + e4);
      newcol[ch].c = e0 + (e1 << 1) + e2 + (e2 << 1) + (e3 << 1) + e4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      for (int k = 0; k < TAP_ROWS - 1; k++) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          win_q[k][ch] <= s1_q.clear ? '0 : win_q[k+1][ch];
        end
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
        win_q[TAP_ROWS-1][ch] <= newcol[ch];
      end
    end
  end

  // Horizontal sums for centers at window columns 2, 3 and 4 -------------
  logic [SUM_W-1:0] sum [RES_MAX][NUM_CH];
  logic [SUM_W-1:0] s3_sum_q [RES_MAX][NUM_CH];
  logic [PROD_W-1:0] s4_prod_q [RES_MAX][NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum[0][ch] = SUM_W'(win_q[0][ch].a) + SUM_W'(win_q[1][ch].b) + SUM_W'(win_q[2][ch].c)
                 + SUM_W'(win_q[3][ch].b) + SUM_W'(win_q[4][ch].a);
      sum[1][ch] = SUM_W'(win_q[1][ch].a) + SUM_W'(win_q[2][ch].b) + SUM_W'(win_q[3][ch].c)
                 + SUM_W'(win_q[4][ch].b);
      sum[2][ch] = SUM_W'(win_q[2][ch].a) + SUM_W'(win_q[3][ch].b) + SUM_W'(win_q[4][ch].c);
    end
  end

  // The division by 35 is a multiply by 2^18/35 rounded up, exact below 8926.
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < RES_MAX; d++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s3_sum_q[d][ch]  <= sum[d][ch];
        s4_prod_q[d][ch] <= PROD_W'(INV_BASE - s3_sum_q[d][ch]) * PROD_W'(RECIP);
      end
    end
    s2_emit_q <= s1_q.emit;
    s2_eof_q  <= s1_q.eof;
    s3_emit_q <= s2_emit_q;
    s3_eof_q  <= s2_eof_q;
    s4_emit_q <= s3_emit_q;
    s4_eof_q  <= s3_eof_q;
    if (issue) begin
      s1_q <= op;
    end
  end

  // Result queue: up to three writes per cycle, one read ------------------
  res_t             fifo_q [RESQ_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [RES_MAX-1:0] wr_mask;
  logic [1:0]       n_wr;
  logic             do_pop;
  res_t             wr_res [RES_MAX];
  logic [PTR_W-1:0] wr_idx [RES_MAX];

  assign wr_mask = s4_valid_q ? s4_emit_q : '0;
  assign n_wr    = popcnt3(wr_mask);
  assign empty_o = count_q == '0;
  assign res_o   = fifo_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;
  assign wptr_d  = wptr_q + PTR_W'(n_wr);
  assign rptr_d  = rptr_q + PTR_W'(do_pop);
  assign count_d = count_q + CNT_W'(n_wr) - CNT_W'(do_pop);

  always_comb begin
    for (int d = 0; d < RES_MAX; d++) begin
      wr_res[d].blue_out     = s4_prod_q[d][0][RECIP_SHIFT +: CH_W];
      wr_res[d].green_out    = s4_prod_q[d][1][RECIP_SHIFT +: CH_W];
      wr_res[d].red_out      = s4_prod_q[d][2][RECIP_SHIFT +: CH_W];
      wr_res[d].last_of_run  = (wr_mask >> (d + 1)) == '0;
      wr_res[d].end_of_frame = s4_eof_q && ((wr_mask >> (d + 1)) == '0);
    end
    wr_idx[0] = wptr_q;
    wr_idx[1] = wptr_q + PTR_W'(wr_mask[0]);
    wr_idx[2] = wptr_q + PTR_W'(wr_mask[0]) + PTR_W'(wr_mask[1]);
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < RES_MAX; d++) begin
      if (wr_mask[d]) begin
        fifo_q[wr_idx[d]] <= wr_res[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      count_q    <= '0;
    end else begin
      step_q     <= step_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      count_q    <= count_d;
    end
  end

endmodule

@@ hdl/weighted_blur5_invert_top.sv @@
// Top level of the weighted 5x5 blur with inversion: queue ports, APB registers, front and back.
// Pixels stream in raster order, one request per clock while the queue has room; four past
// rows sit in four line-store banks read in parallel, so a pixel request reads them at once.
// Rows beyond the store are zero. A result passes the job queue, line-store read, window, sum
// and product registers to the result queue, leaving it at one per cycle while popped; a row's
// last pixel yields up to three results. A drain request along a row loads one window column,
// but the first of each drain row, or after a register write, reloads the five-column window.
module weighted_blur5_invert_top import wb5i_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  in_t               in_data_i,
  output logic              empty,
  input  logic              pop,
  output res_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic             cfg_wr, accept, job_valid, jq_valid, jq_pop;
  reg_idx_e         reg_idx;
  job_t             job, jq_job;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (reg_idx)
      REG_WIDTH: begin
        prdata = DATA_W'(width_q);
        if (cfg_wr) width_d = pwdata[DIM_W-1:0];
      end
      REG_HEIGHT: begin
        prdata = DATA_W'(height_q);
        if (cfg_wr) height_d = pwdata[DIM_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign accept = push && !full;

  wb5i_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cfg_wr_i    (cfg_wr),
    .width_i     (width_q),
    .height_i    (height_q),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  wb5i_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job),
    .full_o  (full),
    .valid_o (jq_valid),
    .job_o   (jq_job),
    .pop_i   (jq_pop)
  );

  wb5i_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (jq_valid),
    .job_i       (jq_job),
    .job_pop_o   (jq_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (out_data_o)
  );

endmodule

@@ hdl/wb5i_checker.sv @@
// Port-level checks of the weighted 5x5 blur with inversion, bound to the top level.
module wb5i_checker import wb5i_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic full_i,
  input logic empty_i,
  input logic pop_i,
  input res_t out_data_i
);

  // An edge in reset leaves no result waiting and room for a request.
  a_reset_state: assert property (@(posedge clk_i) !rst_ni |=> (empty_i && !full_i))
    else $error("queue state wrong after reset");

  // A waiting result stays put until it is popped.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(out_data_i)))
    else $error("waiting result changed before pop");

  // The frame's last result always closes its request's run.
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && out_data_i.end_of_frame) |-> out_data_i.last_of_run)
    else $error("end of frame without last of run");

endmodule

bind weighted_blur5_invert_top wb5i_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full_i     (full),
  .empty_i    (empty),
  .pop_i      (pop),
  .out_data_i (out_data_o)
);

@@ bench/tb.sv @@
// Self-checking testbench of the weighted 5x5 blur with inversion: random frames and drains.
`timescale 1ns / 1ps
module tb;
  import wb5i_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_STALL  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t in_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  res_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  weighted_blur5_invert_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Blur predictor state.
  logic [PIX_W-1:0] rows_seen [STORE_ROWS][MAX_WIDTH];
  logic [PIX_W-1:0] win [5][5];
  logic [PIX_W-1:0] taps [5][5];
  logic [DIM_W-1:0] width_reg = RESET_WIDTH;
  logic [DIM_W-1:0] height_reg = RESET_HEIGHT;
  int unsigned in_col = 0, in_row = 0, drain_pos = 0;
  bit frame_done = 0;

  in_t  request_q [$];
  res_t pixel_q [$];
  int unsigned mismatches = 0;
  bit burst = 0;
  bit long_stall_go = 0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Weighs the taps and inverts: floor((8925 - sum) / 35) per channel.
  task automatic push_blurred(bit last, bit eof);
    int unsigned s [3];
    int unsigned k;
    res_t r;
    s = '{0, 0, 0};
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) begin
        k = 1 + ((i >= 1 && i <= 3 && j >= 1 && j <= 3) ? 1 : 0) + ((i == 2 && j == 2) ? 1 : 0);
        for (int ch = 0; ch < 3; ch++) s[ch] += k * taps[i][j][8*ch +: 8];
      end
    r.blue_out     = CH_W'((8925 - s[0]) / 35);
    r.green_out    = CH_W'((8925 - s[1]) / 35);
    r.red_out      = CH_W'((8925 - s[2]) / 35);
    r.last_of_run  = last;
    r.end_of_frame = eof;
    pixel_q.push_back(r);
  endtask

  task automatic blur_step(in_t it);
    int unsigned w, h, c, r, dfirst, first, total, p, y, x;
    int iy, ix;
    logic [PIX_W-1:0] px;
    bit row_end, frame_end;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, HEIGHT_CAP);
    px = {it.red_in, it.green_in, it.blue_in};
    if (it.opcode == OP_PIXEL) begin
      if (frame_done) begin
        frame_done = 0;
        drain_pos = 0;
        in_col = 0;
        in_row = 0;
      end
      c = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
      r = in_row;
      if (c == 0)
        for (int i = 0; i < 5; i++) for (int j = 0; j < 5; j++) win[i][j] = '0;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
        if (i == 4) win[i][4] = px;
        else if (r >= 4 - i) win[i][4] = rows_seen[(r - (4 - i)) & 3][c];
        else win[i][4] = '0;
      end
      rows_seen[r & 3][c] = px;
      row_end = (c + 1 >= w);
      frame_end = row_end && (r + 1 >= h);
      if (r >= 2) begin
        dfirst = row_end ? ((c >= 2) ? 0 : 2 - c) : 0;
        if (row_end || c >= 2)
          for (int d = dfirst; d <= (row_end ? 2 : 0); d++) begin
            for (int i = 0; i < 5; i++)
              for (int j = 0; j < 5; j++) taps[i][j] = (d + j <= 4) ? win[i][d+j] : '0;
            push_blurred(!row_end || d == 2, 0);
          end
      end
      if (row_end) begin
        in_col = 0;
        if (frame_end) begin
          in_row = 0;
          frame_done = 1;
          drain_pos = 0;
        end else begin
          in_row = (r + 1) & 11'h7FF;
        end
      end else begin
        in_col = (c + 1) & 11'h7FF;
      end
    end else if (frame_done) begin
      first = (h >= 2) ? h - 2 : 0;
      total = (h - first) * w;
      p = drain_pos;
      if (p >= total) begin
        frame_done = 0;
      end else begin
        y = first + ((p >= w) ? 1 : 0);
        x = (p >= w) ? p - w : p;
        for (int fy = 0; fy < 5; fy++)
          for (int fx = 0; fx < 5; fx++) begin
            iy = int'(y) - 2 + fy;
            ix = int'(x) - 2 + fx;
            taps[fy][fx] = (iy < 0 || iy >= int'(h) || ix < 0 || ix >= int'(w)) ? '0 :
                           rows_seen[iy & 3][ix];
          end
        p++;
        push_blurred(1, p == total);
        drain_pos = p & 13'h1FFF;
        if (p == total) begin
          frame_done = 0;
          drain_pos = 0;
        end
      end
    end
  endtask

  // Request driver.
  int unsigned tx_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) blur_step(in_data_i);
      if (!push || !full) begin
        if (tx_gap != 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_data_i <= request_q.pop_front();
          push <= 1'b1;
          tx_gap = burst ? 0 : gap_len();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (long_stall_go) stall_left <= LONG_STALL;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Result monitor.
  int unsigned rx_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          if (out_data_o !== pixel_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", pixel_q[0], out_data_o);
          end
          void'(pixel_q.pop_front());
        end
        rx_gap = burst ? 0 : gap_len();
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(opcode_e op, logic [PIX_W-1:0] px);
    in_t it;
    it.opcode = op;
    {it.red_in, it.green_in, it.blue_in} = px;
    request_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || push || pixel_q.size() != 0 || stall_left != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [DIM_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {20'($urandom_range(0, 20'hFFFFF)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    wait_idle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    @(negedge clk_i);
  endtask

  task automatic stall_receiver();
    @(negedge clk_i) long_stall_go = 1;
    @(negedge clk_i) long_stall_go = 0;
  endtask

  task automatic random_frame(int unsigned w, int unsigned h, int unsigned drains);
    for (int unsigned n = 0; n < w * h; n++) begin
      if ($urandom_range(0, 29) == 0) send(OP_DRAIN, PIX_W'($urandom));
      send(OP_PIXEL, PIX_W'($urandom));
    end
    repeat (drains) send(OP_DRAIN, PIX_W'($urandom));
  endtask

  function automatic int unsigned drain_total(int unsigned w, int unsigned h);
    return (h >= 2) ? 2 * w : w;
  endfunction

  initial begin
    int unsigned w, h, pixels_sent, total;
    bit drained;
    for (int i = 0; i < STORE_ROWS; i++)
      for (int j = 0; j < MAX_WIDTH; j++) rows_seen[i][j] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A drain with no finished frame yields nothing.
    send(OP_DRAIN, '0);
    set_frame(3, 3);
    for (int n = 0; n < 9; n++)
      send(OP_PIXEL, (n % 3 == 0) ? 24'h000000 : (n % 3 == 1) ? 24'hFFFFFF : 24'h00FF00);
    repeat (7) send(OP_DRAIN, 24'hFFFFFF);
    // Zero width and height behave as one.
    set_frame(0, 0);
    send(OP_PIXEL, 24'hFFFFFF);
    repeat (2) send(OP_DRAIN, '0);
    // A pixel in the middle of the drain drops the rest and opens a new frame.
    set_frame(2, 5);
    random_frame(2, 5, 1);
    random_frame(2, 5, 4);

    // Receiver holds off while a burst of pixels fills the block.
    set_frame(8, 6);
    burst = 1;
    stall_receiver();
    random_frame(8, 6, 16);
    wait_idle();
    burst = 0;

    // Oversized registers clamp, so a short row keeps going; a narrower width then ends it.
    set_frame(12'hFFF, 12'hFFF);
    repeat (5) send(OP_PIXEL, PIX_W'($urandom));
    set_frame(3, 1);
    send(OP_PIXEL, PIX_W'($urandom));
    repeat (4) send(OP_DRAIN, '0);

    pixels_sent = 0;
    drained = 1;
    w = 1;
    h = 1;
    while (pixels_sent < 220) begin
      if (drained) begin
        w = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
        h = $urandom_range(1, 7);
        set_frame(w, h);
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) stall_receiver();
      end
      total = drain_total(w, h);
      if ($urandom_range(0, 4) == 0) begin
        random_frame(w, h, $urandom_range(0, total - 1));
        drained = 0;
      end else begin
        random_frame(w, h, total + $urandom_range(0, 1));
        drained = 1;
      end
      pixels_sent += w * h;
      if (drained) wait_idle();
    end
    random_frame(w, h, drain_total(w, h));

    wait_idle();
    repeat (30) @(negedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ weighted_blur5_invert_top.f @@
hdl/wb5i_pkg.sv
hdl/wb5i_front.sv
hdl/wb5i_jobq.sv
hdl/wb5i_back.sv
hdl/weighted_blur5_invert_top.sv
hdl/wb5i_checker.sv
bench/tb.sv
